>>> sv/chtb_pkg.sv
`default_nettype none

package chtb_pkg;

    // Default geometry
    localparam int CHTB_TABLE_SIZE   = 251;
    localparam int CHTB_MAX_BACKENDS = 16;

    // Fixed field widths
    localparam int CFG_W     = 5;
    localparam int KEY_W     = 32;
    localparam int BACKEND_W = 4;

    // Operation codes carried in func
    typedef enum logic {
        FUNC_REBUILD = 1'b0,
        FUNC_LOOKUP  = 1'b1
    } t_func;

    // Permutation hash constants: offset from (HA_MUL*i+HA_ADD) mod HA_MOD,
    // skip from (HS_MUL*i+HS_ADD) mod HS_MOD
    localparam int HA_MUL = 5;
    localparam int HA_ADD = 9;
    localparam int HA_MOD = 211;
    localparam int HS_MUL = 12;
    localparam int HS_ADD = 2;
    localparam int HS_MOD = 379;
    localparam int A_W    = $clog2(HA_MOD);
    localparam int B_W    = $clog2(HS_MOD);

    // Key reduction: DIG_W key bits folded into the remainder per cycle
    localparam int DIG_W     = 4;
    localparam int DIG_STEPS = KEY_W / DIG_W;
    localparam int DIG_CNT_W = $clog2(DIG_STEPS);

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic init_red;
        logic init_write;
        logic prm_read;
        logic prm_load;
        logic taken_read;
        logic advance;
        logic claim;
        logic prm_write;
        logic sweep_start;
        logic sweep_step;
        logic build_done;
        logic lk_step;
        logic own_read;
        logic emit;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic clr_last;
        logic red_done;
        logic last_bk;
        logic probe_exh;
        logic taken;
        logic full;
        logic progress;
        logic sweep_end;
        logic dig_last;
        logic ready_flag;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> sv/chtb_ifs.sv
`default_nettype none

interface chtb_in_if
    import chtb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] flow_key;

    modport source (output valid, output func, output flow_key, input ready);
    modport sink   (input valid, input func, input flow_key, output ready);
endinterface

interface chtb_out_if
    import chtb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BACKEND_W-1:0] backend;
    logic                 table_ready;

    modport source (output valid, output backend, output table_ready, input ready);
    modport sink   (input valid, input backend, input table_ready, output ready);
endinterface

interface chtb_cfg_if
    import chtb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/chtb_ram.sv
`default_nettype none

module chtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/chtb_ctrl.sv
`default_nettype none

module chtb_ctrl
    import chtb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_func,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_CLEAR   = 14'b00000000000010,
        S_INIT    = 14'b00000000000100,
        S_FILL_RD = 14'b00000000001000,
        S_FILL_LD = 14'b00000000010000,
        S_PROBE   = 14'b00000000100000,
        S_CHECK   = 14'b00000001000000,
        S_NEXT    = 14'b00000010000000,
        S_SWEEP   = 14'b00000100000000,
        S_LK_RED  = 14'b00001000000000,
        S_LK_RD   = 14'b00010000000000,
        S_EMIT    = 14'b00100000000000,
        S_SPARE0  = 14'b01000000000000,
        S_SPARE1  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_func == FUNC_REBUILD) begin
                        n_state = S_CLEAR;
                    end else if (i_sts.ready_flag) begin
                        n_state = S_LK_RED;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (i_sts.red_done) begin
                    o_cmd.init_write = 1'b1;
                    if (i_sts.last_bk) begin
                        n_state = S_FILL_RD;
                    end
                end else begin
                    o_cmd.init_red = 1'b1;
                end
            end
            S_FILL_RD: begin
                o_cmd.prm_read = 1'b1;
                n_state        = S_FILL_LD;
            end
            S_FILL_LD: begin
                o_cmd.prm_load = 1'b1;
                n_state        = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.probe_exh) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.taken_read = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.taken) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_PROBE;
                end else begin
                    o_cmd.claim = 1'b1;
                    n_state     = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.prm_write = 1'b1;
                if (i_sts.full) begin
                    o_cmd.build_done = 1'b1;
                    n_state          = S_EMIT;
                end else if (i_sts.last_bk && !i_sts.progress) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_SWEEP;
                end else begin
                    n_state = S_FILL_RD;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_end) begin
                    o_cmd.build_done = 1'b1;
                    n_state          = S_EMIT;
                end
            end
            S_LK_RED: begin
                o_cmd.lk_step = 1'b1;
                if (i_sts.dig_last) begin
                    n_state = S_LK_RD;
                end
            end
            S_LK_RD: begin
                o_cmd.own_read = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/chtb_dp.sv
`default_nettype none

module chtb_dp
    import chtb_pkg::*;
#(
    parameter int TABLE_SIZE   = CHTB_TABLE_SIZE,
    parameter int MAX_BACKENDS = CHTB_MAX_BACKENDS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic                 i_in_func,
    input  wire logic [KEY_W-1:0]     i_flow_key,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_cfg_ready,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [BACKEND_W-1:0]      o_backend,
    output logic                      o_table_ready
);

    localparam int SW     = $clog2(TABLE_SIZE);
    localparam int PW     = $clog2(TABLE_SIZE + 1);
    localparam int BW     = $clog2(MAX_BACKENDS);
    localparam int NB_CAP = (MAX_BACKENDS < TABLE_SIZE) ? MAX_BACKENDS : TABLE_SIZE;
    localparam int NW     = ($clog2(NB_CAP + 1) > CFG_W) ? $clog2(NB_CAP + 1) : CFG_W;
    localparam int RW     = ((SW + 1) > B_W) ? (SW + 1) : B_W;
    localparam int PRM_W  = 2 * SW + PW;

    // Control state
    logic                 r_ready_flag;
    logic                 r_out_valid;
    logic [CFG_W-1:0]     r_num_backends;

    // Build working registers
    logic [BW-1:0]        r_last;
    logic [BW-1:0]        r_bk;
    logic [A_W-1:0]       r_a;
    logic [B_W-1:0]       r_b;
    logic [RW-1:0]        r_ra;
    logic [RW-1:0]        r_rb;
    logic [PW-1:0]        r_k;
    logic [PW-1:0]        r_filled;
    logic                 r_progress;
    logic [SW-1:0]        r_cand;
    logic [SW-1:0]        r_skip;
    logic [PW-1:0]        r_probes;

    // Lookup and result registers
    logic                 r_is_lookup;
    logic [KEY_W-1:0]     r_key;
    logic [SW-1:0]        r_rem;
    logic [DIG_CNT_W-1:0] r_dig;
    logic [BACKEND_W-1:0] r_out_backend;
    logic                 r_out_table_ready;

    // Combinational helpers
    logic [NW-1:0]        nb_ext;
    logic [NW-1:0]        nb_min1;
    logic [NW-1:0]        nb_eff;
    logic [BW-1:0]        last_bk;
    logic [A_W:0]         a_sum;
    logic [A_W:0]         a_wrap;
    logic [B_W:0]         b_sum;
    logic [B_W:0]         b_wrap;
    logic [RW-1:0]        ra_red;
    logic [RW-1:0]        rb_red;
    logic [SW:0]          adv_sum;
    logic [SW:0]          adv_wrap;
    logic [SW-1:0]        cand_adv;
    logic [SW:0]          rem_t;
    logic [SW-1:0]        rem_nxt;
    logic [BW-1:0]        bk_nxt;
    logic [SW-1:0]        sweep_addr;
    logic                 sweep_rd;

    // RAM ports
    logic                 prm_we;
    logic [PRM_W-1:0]     prm_wdata;
    logic [PRM_W-1:0]     prm_rdata;
    logic                 tkn_we;
    logic [SW-1:0]        tkn_waddr;
    logic                 tkn_re;
    logic [SW-1:0]        tkn_raddr;
    logic                 tkn_rdata;
    logic                 own_we;
    logic [SW-1:0]        own_waddr;
    logic [BACKEND_W-1:0] own_wdata;
    logic [BACKEND_W-1:0] own_rdata;

    // Effective backend count: zero counts as one, capped by both limits
    assign nb_ext  = NW'(r_num_backends);
    assign nb_min1 = (nb_ext == '0) ? NW'(1) : nb_ext;
    assign nb_eff  = (nb_min1 > NW'(NB_CAP)) ? NW'(NB_CAP) : nb_min1;
    assign last_bk = BW'(nb_eff - NW'(1));

    // Running hash terms, stepped once per backend
    assign a_sum  = {1'b0, r_a} + (A_W + 1)'(HA_MUL);
    assign a_wrap = (a_sum >= (A_W + 1)'(HA_MOD)) ? a_sum - (A_W + 1)'(HA_MOD) : a_sum;
    assign b_sum  = {1'b0, r_b} + (B_W + 1)'(HS_MUL);
    assign b_wrap = (b_sum >= (B_W + 1)'(HS_MOD)) ? b_sum - (B_W + 1)'(HS_MOD) : b_sum;

    // Reduction of offset mod M and skip mod M-1, one subtract per cycle
    assign ra_red = (r_ra >= RW'(TABLE_SIZE)) ? r_ra - RW'(TABLE_SIZE) : r_ra;
    assign rb_red = (r_rb >= RW'(TABLE_SIZE - 1)) ? r_rb - RW'(TABLE_SIZE - 1) : r_rb;

    // Permutation step
    assign adv_sum  = {1'b0, r_cand} + {1'b0, r_skip};
    assign adv_wrap = (adv_sum >= (SW + 1)'(TABLE_SIZE)) ? adv_sum - (SW + 1)'(TABLE_SIZE)
                                                         : adv_sum;
    assign cand_adv = adv_wrap[SW-1:0];

    assign bk_nxt = (r_bk == r_last) ? '0 : r_bk + BW'(1);

    // Key mod M, DIG_W bits of restoring reduction per cycle
    always_comb begin
        rem_nxt = r_rem;
        rem_t   = '0;
        for (int d = 0; d < DIG_W; d++) begin
            rem_t = {rem_nxt, r_key[KEY_W-1-d]};
            if (rem_t >= (SW + 1)'(TABLE_SIZE)) begin
                rem_t = rem_t - (SW + 1)'(TABLE_SIZE);
            end
            rem_nxt = rem_t[SW-1:0];
        end
    end

    // Final sweep: read slot k, write owner of slot k-1 in the next cycle
    assign sweep_rd   = i_cmd.sweep_step && (r_k != PW'(TABLE_SIZE));
    assign sweep_addr = SW'(r_k - PW'(1));

    // Per-backend walk state: {candidate, skip, probes}
    assign prm_we    = i_cmd.init_write || i_cmd.prm_write;
    assign prm_wdata = i_cmd.init_write ? {SW'(r_ra), SW'(r_rb) + SW'(1), PW'(0)}
                                        : {r_cand, r_skip, r_probes};

    assign tkn_we    = i_cmd.clr_step || i_cmd.claim;
    assign tkn_waddr = i_cmd.clr_step ? r_k[SW-1:0] : r_cand;
    assign tkn_re    = i_cmd.taken_read || sweep_rd;
    assign tkn_raddr = i_cmd.taken_read ? r_cand : r_k[SW-1:0];

    assign own_we    = i_cmd.claim || (i_cmd.sweep_step && (r_k != '0) && !tkn_rdata);
    assign own_waddr = i_cmd.claim ? r_cand : sweep_addr;
    assign own_wdata = i_cmd.claim ? BACKEND_W'(r_bk) : '0;

    chtb_ram #(
        .WIDTH (PRM_W),
        .DEPTH (MAX_BACKENDS)
    ) u_prm_ram (
        .i_clk   (i_clk),
        .i_we    (prm_we),
        .i_waddr (r_bk),
        .i_wdata (prm_wdata),
        .i_re    (i_cmd.prm_read),
        .i_raddr (r_bk),
        .o_rdata (prm_rdata)
    );

    chtb_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SIZE)
    ) u_tkn_ram (
        .i_clk   (i_clk),
        .i_we    (tkn_we),
        .i_waddr (tkn_waddr),
        .i_wdata (i_cmd.claim),
        .i_re    (tkn_re),
        .i_raddr (tkn_raddr),
        .o_rdata (tkn_rdata)
    );

    chtb_ram #(
        .WIDTH (BACKEND_W),
        .DEPTH (TABLE_SIZE)
    ) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_re    (i_cmd.own_read),
        .i_raddr (r_rem),
        .o_rdata (own_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_flag   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_num_backends <= CFG_W'(1);
        end else begin
            if (i_cfg_valid) begin
                r_num_backends <= i_cfg_data;
            end
            if (i_cmd.build_done) begin
                r_ready_flag <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_lookup <= i_in_func;
            r_key       <= i_flow_key;
            r_rem       <= '0;
            r_dig       <= '0;
            r_last      <= last_bk;
            r_bk        <= '0;
            r_k         <= '0;
            r_filled    <= '0;
            r_progress  <= 1'b0;
            r_a         <= A_W'(HA_ADD % HA_MOD);
            r_ra        <= RW'(HA_ADD % HA_MOD);
            r_b         <= B_W'(HS_ADD % HS_MOD);
            r_rb        <= RW'(HS_ADD % HS_MOD);
        end
        if (i_cmd.clr_step || sweep_rd) begin
            r_k <= r_k + PW'(1);
        end
        if (i_cmd.sweep_start) begin
            r_k <= '0;
        end
        if (i_cmd.init_red) begin
            r_ra <= ra_red;
            r_rb <= rb_red;
        end
        if (i_cmd.init_write) begin
            r_a  <= a_wrap[A_W-1:0];
            r_ra <= RW'(a_wrap[A_W-1:0]);
            r_b  <= b_wrap[B_W-1:0];
            r_rb <= RW'(b_wrap[B_W-1:0]);
            r_bk <= bk_nxt;
        end
        if (i_cmd.prm_load) begin
            {r_cand, r_skip, r_probes} <= prm_rdata;
        end
        if (i_cmd.advance || i_cmd.claim) begin
            r_cand   <= cand_adv;
            r_probes <= r_probes + PW'(1);
        end
        if (i_cmd.claim) begin
            r_filled   <= r_filled + PW'(1);
            r_progress <= 1'b1;
        end
        if (i_cmd.prm_write) begin
            r_bk <= bk_nxt;
            if (r_bk == r_last) begin
                r_progress <= 1'b0;
            end
        end
        if (i_cmd.lk_step) begin
            r_rem <= rem_nxt;
            r_key <= r_key << DIG_W;
            r_dig <= r_dig + DIG_CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_backend     <= (r_is_lookup && r_ready_flag) ? own_rdata : '0;
            r_out_table_ready <= r_ready_flag;
        end
    end

    assign o_sts.clr_last   = (r_k == PW'(TABLE_SIZE - 1));
    assign o_sts.red_done   = (r_ra < RW'(TABLE_SIZE)) && (r_rb < RW'(TABLE_SIZE - 1));
    assign o_sts.last_bk    = (r_bk == r_last);
    assign o_sts.probe_exh  = (r_probes >= PW'(TABLE_SIZE));
    assign o_sts.taken      = tkn_rdata;
    assign o_sts.full       = (r_filled == PW'(TABLE_SIZE));
    assign o_sts.progress   = r_progress;
    assign o_sts.sweep_end  = (r_k == PW'(TABLE_SIZE));
    assign o_sts.dig_last   = (r_dig == DIG_CNT_W'(DIG_STEPS - 1));
    assign o_sts.ready_flag = r_ready_flag;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_backend     = r_out_backend;
    assign o_table_ready = r_out_table_ready;

endmodule

`default_nettype wire

>>> sv/consistent_hash_table_builder.sv
`default_nettype none

// Consistent-hash table builder. Holds a TABLE_SIZE-slot table that maps a
// flow key to one of up to num_backends backends, built by the round-robin
// permutation fill: backend i starts at ((5i+9) mod 211) mod M and steps by
// ((12i+2) mod 379) mod (M-1) + 1, each claiming the next free slot in turn.
// Slots no permutation can reach (non-prime M) go to backend 0. Each input
// beat gives exactly one output beat. func=0 rebuilds and answers backend 0,
// table_ready 1. func=1 looks up flow_key mod M and answers the owner with
// table_ready 1, or 0/0 if no build has finished yet. num_backends is taken
// at the start of each rebuild (0 acts as 1, capped at MAX_BACKENDS and M);
// writing it leaves the standing table alone. The block works on one item
// at a time. A lookup reduces the key remainder (4 key bits per cycle),
// reads the owner RAM and loads the output register once that is free;
// the next item is taken the cycle after. A rebuild clears the occupancy
// RAM, then per backend subtracts once per cycle while either term still
// reaches the table size and then stores its start and step, then runs the
// fill walk, in which each backend visit reads and loads its walk state,
// probes the occupancy RAM until it finds a free slot or has run out, and
// writes the walk state back, and a final sweep when the walk stalls before
// every slot is owned. The output register lets the next item be accepted
// while a result beat still waits.

module consistent_hash_table_builder
    import chtb_pkg::*;
#(
    parameter int TABLE_SIZE   = CHTB_TABLE_SIZE,
    parameter int MAX_BACKENDS = CHTB_MAX_BACKENDS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    chtb_cfg_if.sink    i_cfg,
    chtb_in_if.sink     i_in,
    chtb_out_if.source  o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: clear, per-backend init, fill walk, sweep, lookup, emit
    chtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Counters, walk registers, the three RAMs and the output register
    chtb_dp #(
        .TABLE_SIZE   (TABLE_SIZE),
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_func     (i_in.func),
        .i_flow_key    (i_in.flow_key),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_cfg_ready   (i_cfg.ready),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_backend     (o_out.backend),
        .o_table_ready (o_out.table_ready)
    );

endmodule

`default_nettype wire

>>> sv/chtb_checker.sv
`default_nettype none

module chtb_checker
    import chtb_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [BACKEND_W-1:0] i_out_backend,
    input wire logic                 i_out_table_ready
);

    logic r_seen_ready;

    // Sticky: some result beat has reported a finished table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ready <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_table_ready) begin
            r_seen_ready <= 1'b1;
        end
    end

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_backend) && $stable(i_out_table_ready))
        else $error("result beat changed while stalled");

    // One item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    // No table, no owner
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_table_ready |-> i_out_backend == '0)
        else $error("owner reported without a finished table");

    // A finished table stays finished
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_ready |-> i_out_table_ready)
        else $error("table_ready dropped after a finished build");

endmodule

bind consistent_hash_table_builder chtb_checker u_chtb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_backend     (o_out.backend),
    .i_out_table_ready (o_out.table_ready)
);

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top
    import chtb_pkg::*;
();

    // Geometry of the block under test (default parameters)
    localparam int TBL = CHTB_TABLE_SIZE;
    localparam int NB  = CHTB_MAX_BACKENDS;

    // Cycle budget: many times what the slowest run takes
    localparam int CYCLE_LIMIT = 3_000_000;

    // Receiver long hold-offs, keyed to the number of input beats taken so far
    localparam int HOLD_AT_FIRST  = 300;
    localparam int HOLD_AT_SECOND = 900;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        t_func            op;
        logic [KEY_W-1:0] key;
    } t_flow_item;

    typedef struct {
        logic [BACKEND_W-1:0] backend;
        logic                 table_ready;
    } t_owner_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    chtb_cfg_if cfg_if ();
    chtb_in_if  in_if ();
    chtb_out_if out_if ();

    consistent_hash_table_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the table and the backend count
    // ------------------------------------------------------------------
    logic [BACKEND_W-1:0] owner_tab [TBL];
    bit                   table_built;
    logic [CFG_W-1:0]     backends_reg;

    t_flow_item   flow_items_q [$];     // waiting to be offered to the block
    t_owner_reply owner_replies_q [$];  // expected replies, oldest first

    int   errors;
    int   beats_in;
    int   cycle_cnt;
    bit   no_idle;

    // Driver state
    int         burst_left;
    int         gap_left;
    t_flow_item nxt_item;

    // Receiver state
    logic [31:0] stall_pat;
    int          pat_age;
    int          hold_left;
    int          holds_done;

    // Monitor scratch
    t_owner_reply want;

    // Round-robin permutation fill. Each backend walks offset + j*skip,
    // steps over taken slots and claims the first free one. A backend that
    // has tried every position drops out; a round with no claim ends the walk
    // and whatever is still free goes to backend 0.
    function automatic void fill_table();
        int n;
        int filled;
        int i;
        int pos   [NB];
        int stp   [NB];
        int tries [NB];
        bit used  [TBL];
        bit moved;
        n = int'(backends_reg);
        if (n == 0) n = 1;
        if (n > NB) n = NB;
        if (n > TBL) n = TBL;
        filled = 0;
        for (i = 0; i < TBL; i++) used[i] = 1'b0;
        for (i = 0; i < n; i++) begin
            pos[i]   = ((HA_MUL * i + HA_ADD) % HA_MOD) % TBL;
            stp[i]   = ((HS_MUL * i + HS_ADD) % HS_MOD) % (TBL - 1) + 1;
            tries[i] = 0;
        end
        moved = 1'b1;
        while (filled < TBL && moved) begin
            moved = 1'b0;
            for (i = 0; i < n && filled < TBL; i++) begin
                while (tries[i] < TBL && used[pos[i]]) begin
                    pos[i] = (pos[i] + stp[i]) % TBL;
                    tries[i]++;
                end
                if (tries[i] < TBL) begin
                    used[pos[i]]      = 1'b1;
                    owner_tab[pos[i]] = i[BACKEND_W-1:0];
                    pos[i]            = (pos[i] + stp[i]) % TBL;
                    tries[i]++;
                    filled++;
                    moved = 1'b1;
                end
            end
        end
        for (i = 0; i < TBL; i++) begin
            if (!used[i]) owner_tab[i] = '0;
        end
        table_built = 1'b1;
    endfunction

    // Works out the reply to one accepted input beat and queues it
    function automatic void serve_item(input t_func op, input logic [KEY_W-1:0] key);
        t_owner_reply r;
        int unsigned  k;
        k = key;
        if (op == FUNC_REBUILD) begin
            fill_table();
            r.backend     = '0;
            r.table_ready = 1'b1;
        end else if (!table_built) begin
            r.backend     = '0;
            r.table_ready = 1'b0;
        end else begin
            r.backend     = owner_tab[k % TBL];
            r.table_ready = 1'b1;
        end
        owner_replies_q.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    endtask

    task automatic push_item(input t_func op, input logic [KEY_W-1:0] key);
        t_flow_item it;
        it.op  = op;
        it.key = key;
        flow_items_q.push_back(it);
    endtask

    // Idle means nothing queued, nothing offered and every reply back.
    // Checked on the falling edge so the driver's edge updates have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (flow_items_q.size() != 0 || in_if.valid || owner_replies_q.size() != 0);
    endtask

    // Register write: only ever called with the block idle
    task automatic write_backends(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        backends_reg = v;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items in bursts, with random gaps between them.
    // A beat moves when valid and ready are both high at the edge; the
    // prediction is taken at that moment.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid    <= 1'b0;
            in_if.func     <= FUNC_LOOKUP;
            in_if.flow_key <= '0;
            burst_left     <= 0;
            gap_left       <= 0;
            beats_in       <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                serve_item(t_func'(in_if.func), in_if.flow_key);
                beats_in <= beats_in + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0 && !no_idle) begin
                    in_if.valid <= 1'b0;
                    gap_left    <= gap_left - 1;
                end else if (flow_items_q.size() != 0) begin
                    nxt_item = flow_items_q.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.func     <= nxt_item.op;
                    in_if.flow_key <= nxt_item.key;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                        gap_left   <= 0;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                    gap_left    <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating 32-bit pattern that is re-picked
    // once all 32 bits are used (always ready, random, mostly stalled, mostly ready).
    // Twice in the run it holds off for a long stretch while the sender
    // carries on, so the block fills and backs up its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_pat    <= '1;
            pat_age      <= 0;
            hold_left    <= 0;
            holds_done   <= 0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (holds_done < 2 &&
                     beats_in >= ((holds_done == 0) ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
            out_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
        end else begin
            out_if.ready <= stall_pat[0];
            if (pat_age == 31) begin
                pat_age <= 0;
                case ($urandom_range(0, 3))
                    0: begin
                        stall_pat <= '1;
                    end
                    1: begin
                        stall_pat <= $urandom;
                    end
                    2: begin
                        stall_pat <= $urandom & $urandom;
                    end
                    default: begin
                        stall_pat <= $urandom | $urandom;
                    end
                endcase
            end else begin
                pat_age   <= pat_age + 1;
                stall_pat <= {stall_pat[0], stall_pat[31:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result beat is checked against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (owner_replies_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", out_if.backend, 0);
            end else begin
                want = owner_replies_q.pop_front();
                if (out_if.backend !== want.backend)
                    report_mismatch("backend", out_if.backend, want.backend);
                if (out_if.table_ready !== want.table_ready)
                    report_mismatch("table_ready", out_if.table_ready, want.table_ready);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] phase_cfg [8];
        int               p;
        int               j;
        int               pick;
        logic [KEY_W-1:0] key;

        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        in_if.valid  = 1'b0;
        in_if.func   = FUNC_LOOKUP;
        in_if.flow_key = '0;
        out_if.ready = 1'b0;
        errors       = 0;
        cycle_cnt    = 0;
        no_idle      = 1'b0;
        table_built  = 1'b0;
        backends_reg = 5'd1;    // register value after reset
        for (j = 0; j < TBL; j++) owner_tab[j] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);

        // Lookups before any build answer not-ready; then build with the
        // reset count of one backend and probe the key extremes.
        push_item(FUNC_LOOKUP,  32'h0000_0000);
        push_item(FUNC_LOOKUP,  32'hFFFF_FFFF);
        push_item(FUNC_REBUILD, 32'hDEAD_BEEF);
        push_item(FUNC_LOOKUP,  32'h0000_0000);
        push_item(FUNC_LOOKUP,  32'(TBL - 1));
        push_item(FUNC_LOOKUP,  32'(TBL));
        push_item(FUNC_LOOKUP,  32'hFFFF_FFFF);
        wait_idle();

        // New count must not disturb the standing table until a rebuild
        write_backends(5'd16);
        push_item(FUNC_LOOKUP,  32'd7);
        push_item(FUNC_LOOKUP,  32'd100);
        push_item(FUNC_REBUILD, 32'h0000_0000);
        push_item(FUNC_LOOKUP,  32'd0);
        push_item(FUNC_LOOKUP,  32'd1);
        push_item(FUNC_LOOKUP,  32'd2);
        push_item(FUNC_LOOKUP,  32'd3);
        push_item(FUNC_LOOKUP,  32'hAAAA_AAAA);
        push_item(FUNC_LOOKUP,  32'h5555_5555);
        push_item(FUNC_LOOKUP,  32'(TBL - 1));
        wait_idle();

        // Zero backends acts as one
        write_backends(5'd0);
        push_item(FUNC_REBUILD, 32'hFFFF_FFFF);
        push_item(FUNC_LOOKUP,  32'h1234_5678);
        push_item(FUNC_LOOKUP,  32'(TBL - 2));
        wait_idle();

        // Above the maximum is cut down to the maximum
        write_backends(5'd31);
        push_item(FUNC_REBUILD, 32'h0000_0000);
        push_item(FUNC_LOOKUP,  32'd0);
        push_item(FUNC_LOOKUP,  32'd10);
        push_item(FUNC_LOOKUP,  32'hFFFF_FFFE);
        wait_idle();

        // Random phases: each starts with a rebuild at the new count, then
        // mostly lookups with the odd rebuild thrown in
        phase_cfg[0] = 5'd16;
        phase_cfg[1] = 5'd1;
        phase_cfg[2] = 5'($urandom_range(2, 15));
        phase_cfg[3] = 5'd0;
        phase_cfg[4] = 5'd31;
        phase_cfg[5] = 5'($urandom_range(17, 30));
        phase_cfg[6] = 5'($urandom_range(2, 15));
        phase_cfg[7] = 5'($urandom_range(0, 31));

        for (p = 0; p < 8; p++) begin
            write_backends(phase_cfg[p]);
            no_idle = (p == 2);   // one phase with the sender never idling
            push_item(FUNC_REBUILD, $urandom);
            for (j = 0; j < 150; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    push_item(FUNC_REBUILD, $urandom);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        key = $urandom;
                    else if (pick < 85)
                        key = 32'($urandom_range(0, 17_000_000)) * TBL
                              + 32'($urandom_range(0, 2));
                    else if (pick < 92)
                        key = 32'($urandom_range(0, 2 * TBL));
                    else
                        key = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * TBL));
                    push_item(FUNC_LOOKUP, key);
                end
            end
            wait_idle();
        end
        no_idle = 1'b0;

        // Let any stray beat show itself before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
